/* rtl/fair_share_task_scheduler_macros.svh */
// ----------------------------------------------------------------------------
// fair share task scheduler assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef FAIR_SHARE_TASK_SCHEDULER_MACROS_SVH
`define FAIR_SHARE_TASK_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge out of reset
`define FSTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fsts assertion failed");

// condition must never be seen out of reset
`define FSTS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fsts forbidden condition seen");

`else

`define FSTS_ASSERT(lbl, clk, rst_n, prop)
`define FSTS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/fsts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsts_pkg
// shared types, constants and helper functions of the fair share scheduler
// ----------------------------------------------------------------------------
package fsts_pkg;

    localparam int ID_SPACE  = 16;
    localparam int ID_W      = 4;
    localparam int CNT_W     = ID_W + 1;
    localparam int ELAPSED_W = 20;
    localparam int WEIGHT_W  = 9;
    localparam int CHARGE_W  = ELAPSED_W + WEIGHT_W;
    localparam int VTIME_W   = 48;
    localparam int STAMP_W   = 32;
    localparam int LEVEL_W   = 3;

    localparam int MAX_TASKS   = 16;
    localparam int NICE_LEVELS = 5;

    localparam int NICE_LO_RAW = -((NICE_LEVELS - 1) / 2);
    localparam int NICE_HI_RAW = (NICE_LEVELS - 1) + NICE_LO_RAW;
    localparam int NICE_LO     = (NICE_LO_RAW < -4) ? -4 : NICE_LO_RAW;
    localparam int NICE_HI     = (NICE_HI_RAW > 3) ? 3 : NICE_HI_RAW;

    localparam logic [VTIME_W-1:0] VTIME_MAX = '1;

    // 1.25^nice in q1.8, indexed by nice + 4
    localparam logic [WEIGHT_W-1:0] WEIGHT_Q88 [0:7] = '{
        9'd105, 9'd131, 9'd164, 9'd205, 9'd256, 9'd320, 9'd400, 9'd500
    };

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SLICE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_DUP  = 2'd2
    } fsts_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD,
        ST_CHG_RD,
        ST_CHG_MUL,
        ST_CHG_WB,
        ST_SCAN,
        ST_SCAN_END,
        ST_RESULT
    } fsts_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [VTIME_W-1:0] vtime;
        logic [STAMP_W-1:0] stamp;
    } fsts_entry_t;

    typedef struct packed {
        logic load;
        logic add_exec;
        logic chg_rd;
        logic chg_mul;
        logic chg_wb;
        logic scan_step;
        logic result_load;
    } fsts_cmd_t;

    typedef struct packed {
        logic is_slice;
        logic charge_needed;
        logic scan_last;
        logic out_busy;
    } fsts_stat_t;

    function automatic logic [LEVEL_W-1:0] clamp_nice(input logic [LEVEL_W-1:0] raw);
        logic signed [LEVEL_W:0] v;
        v = signed'({raw[LEVEL_W-1], raw});
        if (v < NICE_LO) begin
            v = (LEVEL_W + 1)'(NICE_LO);
        end
        if (v > NICE_HI) begin
            v = (LEVEL_W + 1)'(NICE_HI);
        end
        return v[LEVEL_W-1:0];
    endfunction

    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] idx;
        idx = level + 3'd4;
        return WEIGHT_Q88[idx];
    endfunction

endpackage

/* rtl/fsts_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsts_datapath
// task table memory, charge multiplier, minimum scan and result register
// ----------------------------------------------------------------------------
`include "fair_share_task_scheduler_macros.svh"

module fsts_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fsts_pkg::fsts_cmd_t               cmd,
    output fsts_pkg::fsts_stat_t              stat,
    input  logic                              s_opcode,
    input  logic [fsts_pkg::ID_W-1:0]         s_task_id,
    input  logic signed [2:0]                 s_task_nice,
    input  logic [fsts_pkg::ELAPSED_W-1:0]    s_elapsed_ms,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [fsts_pkg::ID_W-1:0]         m_running_task,
    output logic                              m_running_valid,
    output logic [1:0]                        m_status
);

    // latched item
    logic                               op_reg;
    logic [fsts_pkg::ID_W-1:0]          id_reg;
    logic [fsts_pkg::LEVEL_W-1:0]       nice_reg;
    logic [fsts_pkg::ELAPSED_W-1:0]     elapsed_reg;

    // scheduler state
    logic [fsts_pkg::ID_SPACE-1:0]      present_reg;
    logic [fsts_pkg::CNT_W-1:0]         task_count_reg;
    logic [fsts_pkg::STAMP_W-1:0]       seq_reg;
    logic [fsts_pkg::ID_W-1:0]          cur_task_reg;
    logic                               cur_valid_reg;
    logic [fsts_pkg::ID_W-1:0]          cur_task_next;
    logic                               cur_valid_next;
    fsts_pkg::fsts_status_t             status_reg;

    // task table
    fsts_pkg::fsts_entry_t              mem [0:fsts_pkg::ID_SPACE-1];
    fsts_pkg::fsts_entry_t              rd_data_reg;
    fsts_pkg::fsts_entry_t              wr_data;
    logic                               rd_en;
    logic [fsts_pkg::ID_W-1:0]          rd_addr;
    logic                               mem_we;
    logic [fsts_pkg::ID_W-1:0]          wr_addr;

    // charge path
    logic [fsts_pkg::CHARGE_W-1:0]      charge_reg;
    logic [fsts_pkg::CHARGE_W-1:0]      charge_next;
    logic [fsts_pkg::VTIME_W:0]         vtime_sum;
    logic [fsts_pkg::VTIME_W-1:0]       vtime_sat;

    // scan
    logic [fsts_pkg::ID_W-1:0]          scan_idx_reg;
    logic                               cmp_valid_reg;
    logic [fsts_pkg::ID_W-1:0]          cmp_id_reg;
    logic                               found_reg;
    logic [fsts_pkg::ID_W-1:0]          best_id_reg;
    logic [fsts_pkg::VTIME_W-1:0]       best_vtime_reg;
    logic [fsts_pkg::STAMP_W-1:0]       best_stamp_reg;
    logic                               take;

    // add decision
    logic                               dup;
    logic                               full;
    logic                               add_ok;

    // result register
    logic                               m_valid_reg;
    logic [fsts_pkg::ID_W-1:0]          m_running_task_reg;
    logic                               m_running_valid_reg;
    fsts_pkg::fsts_status_t             m_status_reg;

    assign dup    = present_reg[id_reg];
    assign full   = 32'(task_count_reg) >= 32'(fsts_pkg::MAX_TASKS);
    assign add_ok = !dup && !full;

    assign rd_en   = cmd.chg_rd || cmd.scan_step;
    assign rd_addr = cmd.chg_rd ? cur_task_reg : scan_idx_reg;
    assign mem_we  = (cmd.add_exec && add_ok) || cmd.chg_wb;
    assign wr_addr = cmd.chg_wb ? cur_task_reg : id_reg;

    assign charge_next = {{fsts_pkg::WEIGHT_W{1'b0}}, elapsed_reg}
                       * {{fsts_pkg::ELAPSED_W{1'b0}}, fsts_pkg::weight_of(rd_data_reg.level)};
    assign vtime_sum   = {1'b0, rd_data_reg.vtime}
                       + {{(fsts_pkg::VTIME_W + 1 - fsts_pkg::CHARGE_W){1'b0}}, charge_reg};
    assign vtime_sat   = vtime_sum[fsts_pkg::VTIME_W] ? fsts_pkg::VTIME_MAX
                                                      : vtime_sum[fsts_pkg::VTIME_W-1:0];

    always_comb begin
        if (cmd.chg_wb) begin
            wr_data.level = rd_data_reg.level;
            wr_data.vtime = vtime_sat;
        end else begin
            wr_data.level = fsts_pkg::clamp_nice(nice_reg);
            wr_data.vtime = '0;
        end
        wr_data.stamp = seq_reg;
    end

    // least vtime wins, earlier stamp breaks ties
    assign take = cmp_valid_reg && present_reg[cmp_id_reg] &&
                  (!found_reg || (rd_data_reg.vtime < best_vtime_reg) ||
                   ((rd_data_reg.vtime == best_vtime_reg) &&
                    (rd_data_reg.stamp < best_stamp_reg)));

    always_comb begin
        cur_task_next  = cur_task_reg;
        cur_valid_next = cur_valid_reg;
        if (op_reg == fsts_pkg::OP_SLICE) begin
            cur_valid_next = found_reg;
            cur_task_next  = found_reg ? best_id_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_opcode;
            id_reg      <= s_task_id;
            nice_reg    <= s_task_nice;
            elapsed_reg <= s_elapsed_ms;
        end
        if (cmd.chg_mul) begin
            charge_reg <= charge_next;
        end
        if (take) begin
            best_id_reg    <= cmp_id_reg;
            best_vtime_reg <= rd_data_reg.vtime;
            best_stamp_reg <= rd_data_reg.stamp;
        end
        if (cmd.result_load) begin
            m_running_task_reg  <= cur_valid_next ? cur_task_next : '0;
            m_running_valid_reg <= cur_valid_next;
            m_status_reg        <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg    <= '0;
            task_count_reg <= '0;
            seq_reg        <= '0;
            cur_task_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            status_reg     <= fsts_pkg::STATUS_OK;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_id_reg     <= '0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (mem_we) begin
                seq_reg <= seq_reg + 32'd1;
            end
            if (cmd.load) begin
                status_reg   <= fsts_pkg::STATUS_OK;
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            if (cmd.add_exec) begin
                if (dup) begin
                    status_reg <= fsts_pkg::STATUS_DUP;
                end else if (full) begin
                    status_reg <= fsts_pkg::STATUS_FULL;
                end else begin
                    present_reg[id_reg] <= 1'b1;
                    task_count_reg      <= task_count_reg + 1'b1;
                end
            end
            // read issued this cycle is compared on the next
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.scan_step) begin
                cmp_id_reg   <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (take) begin
                found_reg <= 1'b1;
            end
            if (cmd.result_load) begin
                cur_task_reg  <= cur_task_next;
                cur_valid_reg <= cur_valid_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_slice      = (op_reg == fsts_pkg::OP_SLICE);
    assign stat.charge_needed = cur_valid_reg && present_reg[cur_task_reg];
    assign stat.scan_last     = (scan_idx_reg == {fsts_pkg::ID_W{1'b1}});
    assign stat.out_busy      = m_valid_reg && !m_ready;

    assign m_valid         = m_valid_reg;
    assign m_running_task  = m_running_task_reg;
    assign m_running_valid = m_running_valid_reg;
    assign m_status        = m_status_reg;

    `FSTS_ASSERT(a_count_matches, aclk, aresetn, 32'(task_count_reg) == $countones(present_reg))
    `FSTS_ASSERT(a_current_present, aclk, aresetn, cur_valid_reg |-> present_reg[cur_task_reg])
    `FSTS_ASSERT(a_seq_step, aclk, aresetn, mem_we |=> (seq_reg == $past(seq_reg) + 32'd1))
    `FSTS_ASSERT_NEVER(a_add_with_charge, aclk, aresetn, cmd.add_exec && cmd.chg_wb)

endmodule

/* rtl/fsts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsts_ctrl
// sequencer for add, charge, minimum scan and result handoff
// ----------------------------------------------------------------------------
module fsts_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fsts_pkg::fsts_stat_t  stat,
    output fsts_pkg::fsts_cmd_t   cmd
);

    fsts_pkg::fsts_state_t state_reg;
    fsts_pkg::fsts_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fsts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fsts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fsts_pkg::ST_DISPATCH;
                end
            end
            fsts_pkg::ST_DISPATCH: begin
                if (!stat.is_slice) begin
                    state_next = fsts_pkg::ST_ADD;
                end else if (stat.charge_needed) begin
                    state_next = fsts_pkg::ST_CHG_RD;
                end else begin
                    state_next = fsts_pkg::ST_SCAN;
                end
            end
            fsts_pkg::ST_ADD:     state_next = fsts_pkg::ST_RESULT;
            fsts_pkg::ST_CHG_RD:  state_next = fsts_pkg::ST_CHG_MUL;
            fsts_pkg::ST_CHG_MUL: state_next = fsts_pkg::ST_CHG_WB;
            fsts_pkg::ST_CHG_WB:  state_next = fsts_pkg::ST_SCAN;
            fsts_pkg::ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = fsts_pkg::ST_SCAN_END;
                end
            end
            fsts_pkg::ST_SCAN_END: state_next = fsts_pkg::ST_RESULT;
            fsts_pkg::ST_RESULT: begin
                if (!stat.out_busy) begin
                    state_next = fsts_pkg::ST_IDLE;
                end
            end
            default: state_next = fsts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            fsts_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            fsts_pkg::ST_ADD:     cmd.add_exec  = 1'b1;
            fsts_pkg::ST_CHG_RD:  cmd.chg_rd    = 1'b1;
            fsts_pkg::ST_CHG_MUL: cmd.chg_mul   = 1'b1;
            fsts_pkg::ST_CHG_WB:  cmd.chg_wb    = 1'b1;
            fsts_pkg::ST_SCAN:    cmd.scan_step = 1'b1;
            fsts_pkg::ST_RESULT:  cmd.result_load = !stat.out_busy;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/fair_share_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fair_share_task_scheduler
// least virtual runtime scheduler over a sixteen-entry task table
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  opcode, task_id, task_nice, elapsed_ms
//  m_        out        m_valid / m_ready  running_task, running_valid, status
//
//  add: dispatch, add, result; slice end: dispatch, charge read, multiply and
//  write back if charged, scan, scan end, result; the scan reads all sixteen
//  table entries through the single read port of the task memory, one a cycle
//  one item in flight; s_ready is high whenever the sequencer is idle, also
//  while a result waits in the output register; a full one stalls the next
//  synchronous active-low reset empties the table; no clearing pass
// ----------------------------------------------------------------------------
module fair_share_task_scheduler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [fsts_pkg::ID_W-1:0]         s_task_id,
    input  logic signed [2:0]                 s_task_nice,
    input  logic [fsts_pkg::ELAPSED_W-1:0]    s_elapsed_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fsts_pkg::ID_W-1:0]         m_running_task,
    output logic                              m_running_valid,
    output logic [1:0]                        m_status
);

    fsts_pkg::fsts_cmd_t  cmd;
    fsts_pkg::fsts_stat_t stat;

    fsts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fsts_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_opcode        (s_opcode),
        .s_task_id       (s_task_id),
        .s_task_nice     (s_task_nice),
        .s_elapsed_ms    (s_elapsed_ms),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_running_task  (m_running_task),
        .m_running_valid (m_running_valid),
        .m_status        (m_status)
    );

endmodule
